[hdl/shape_display_list_rasterizer_defines.svh]
// assertion macros for the display list rasterizer checker
// expects signals named clk and rst in the scope where a macro is used
`ifndef SHAPE_DISPLAY_LIST_RASTERIZER_DEFINES_SVH
`define SHAPE_DISPLAY_LIST_RASTERIZER_DEFINES_SVH

// clocked assertion, quiet while reset is high
`define SDL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sdl assertion failed");

// clocked assertion that also holds during reset
`define SDL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sdl assertion failed");

`endif

[hdl/sdl_pkg.sv]
// shared types, codes and constants of the display list rasterizer
// no dependencies
package sdl_pkg;

  localparam int MAX_SHAPES_DEF = 128;
  localparam int CANVAS_W_DEF   = 64;
  localparam int CANVAS_H_DEF   = 32;

  localparam int COORD_W    = 10;
  localparam int SPAN_W     = 13;
  localparam int SQ_OP_W    = 12;
  localparam int SQ_W       = 2 * SQ_OP_W;
  localparam int SRCH_STEPS = COORD_W;
  localparam int BIT_W      = 4;
  localparam int IN_W       = 56;
  localparam int OUT_W      = 80;
  localparam int ROW_OUT_W  = 64;
  localparam int COUNT_W    = 8;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_MOD  = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SHP_RECT = 2'd0,
    SHP_LINE = 2'd1,
    SHP_CIRC = 2'd2,
    SHP_TRI  = 2'd3
  } shape_t;

  typedef struct packed {
    shape_t                     shape;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  arg_a;
    logic signed [COORD_W-1:0]  arg_b;
  } obj_t;

  typedef struct packed {
    logic                      en;
    logic signed [SPAN_W-1:0]  lo;
    logic signed [SPAN_W-1:0]  hi;
  } span_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOD_RD,
    ST_MOD_WR,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_ROW_BEGIN,
    ST_OBJ_RD,
    ST_OBJ_LD,
    ST_SQ_A,
    ST_SQ_DY,
    ST_SQ_T,
    ST_SRCH,
    ST_CHK,
    ST_MASK,
    ST_FR_RD,
    ST_FR_OUT,
    ST_DONE
  } state_t;

endpackage

[hdl/sdl_sq.sv]
// shared squaring unit, one registered product per cycle
// depends on sdl_pkg
module sdl_sq import sdl_pkg::*; (
  input  logic                      clk,
  input  logic signed [SQ_OP_W-1:0] op,
  output logic signed [SQ_W-1:0]    sq
);

  logic signed [SQ_W-1:0] op_ext;

  assign op_ext = SQ_W'(op);

  always_ff @(posedge clk) begin
    sq <= op_ext * op_ext;
  end

endmodule

[hdl/sdl_row.sv]
// row painter: turns one shape on one row into column spans and a pixel mask
// depends on sdl_pkg
module sdl_row import sdl_pkg::*; #(
  parameter int CANVAS_W = CANVAS_W_DEF
) (
  input  obj_t                     obj,
  input  logic signed [SPAN_W-1:0] row,
  input  logic [COORD_W-1:0]       half_w,
  output logic [CANVAS_W-1:0]      mask
);

  logic signed [SPAN_W-1:0] x, y, a, b, x2, y2, dy, m;
  span_t spans [3];

  always_comb begin
    x  = SPAN_W'(obj.pos_x);
    y  = SPAN_W'(obj.pos_y);
    a  = SPAN_W'(obj.arg_a);
    b  = SPAN_W'(obj.arg_b);
    x2 = x + a - SPAN_W'(1);
    y2 = y + b - SPAN_W'(1);
    dy = row - y;
    m  = $signed(SPAN_W'(half_w));
    for (int i = 0; i < 3; i++) begin
      spans[i] = '0;
    end
    unique case (obj.shape)
      SHP_RECT: begin
        // top and bottom edges, then the two sides
        spans[0].en = (row == y) || (row == y2);
        spans[0].lo = x;
        spans[0].hi = x2;
        spans[1].en = (row >= y) && (row <= y2);
        spans[1].lo = x;
        spans[1].hi = x;
        spans[2].en = spans[1].en;
        spans[2].lo = x2;
        spans[2].hi = x2;
      end
      SHP_LINE: begin
        if (y == b) begin
          spans[0].en = (row == y);
          spans[0].lo = (x < a) ? x : a;
          spans[0].hi = (x < a) ? a : x;
        end else if (x == a) begin
          spans[0].en = (y < b) ? (row >= y && row <= b) : (row >= b && row <= y);
          spans[0].lo = x;
          spans[0].hi = x;
        end
      end
      SHP_CIRC: begin
        spans[0].en = (a >= 0) && (dy >= -a) && (dy <= a);
        spans[0].lo = x - m;
        spans[0].hi = x + m;
      end
      SHP_TRI: begin
        spans[0].en = (dy >= 0) && (dy < a);
        spans[0].lo = x;
        spans[0].hi = x + dy;
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int c = 0; c < CANVAS_W; c++) begin
      mask[c] = 1'b0;
      for (int i = 0; i < 3; i++) begin
        if (spans[i].en && spans[i].lo <= $signed(SPAN_W'(c)) &&
            $signed(SPAN_W'(c)) <= spans[i].hi) begin
          mask[c] = 1'b1;
        end
      end
    end
  end

endmodule

[hdl/shape_display_list_rasterizer.sv]
// a read passes the decode, frame read and frame output states before its result is offered;
//   accepted add, modify and delete redraw all rows; a delete first moves later entries down
// throughput: one item at a time, ready again after its result is registered
// the redraw cost comes from the shared squarer (circle span search, 10 steps)
// reset clears the object count, the output valid flag and the row valid bits
module shape_display_list_rasterizer import sdl_pkg::*; #(
  parameter int MAX_SHAPES = MAX_SHAPES_DEF,
  parameter int CANVAS_W   = CANVAS_W_DEF,
  parameter int CANVAS_H   = CANVAS_H_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // command[1:0] index[8:2] shape[10:9] pos_x[20:11] pos_y[30:21]
  // arg_a[40:31] arg_b[50:41], zero fill above
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  // status[0] object_count[8:1] row_pixels[72:9], zero fill above
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tvalid,
  input  logic             m_tready
);

  localparam int IW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int CW = $clog2(MAX_SHAPES + 1);
  localparam int RW = $clog2(CANVAS_H);

  state_t state, state_next;

  // latched item
  cmd_t              cmd_r;
  logic [6:0]        cmd_idx;
  obj_t              cmd_obj;
  logic [8:0]        idx9;

  // list and counters
  logic [CW-1:0]     total, k;
  logic [CW:0]       k1_wide;
  logic [CW-1:0]     k1;
  logic [RW-1:0]     r;
  logic              last_row;

  // object store
  obj_t              obj_mem [MAX_SHAPES];
  obj_t              rdata, mem_wdata;
  logic [IW-1:0]     mem_raddr, mem_waddr;
  logic              mem_we;

  // frame store, rows never written since reset read as background
  logic [CANVAS_W-1:0] frame [CANVAS_H];
  logic [CANVAS_W-1:0] frame_q, fr_wdata;
  logic [CANVAS_H-1:0] row_valid;
  logic                fr_we;

  // per object/row working registers
  obj_t                    obj;
  logic signed [SQ_OP_W-1:0] sq_op;
  logic signed [SQ_W-1:0]  prod;
  logic signed [SQ_W:0]    asq, t;
  logic [COORD_W-1:0]      m, cand;
  logic [BIT_W-1:0]        bitn;
  logic                    cand_ok;
  logic signed [SQ_OP_W-1:0] dy;
  logic [CANVAS_W-1:0]     acc, row_mask;

  // result being built
  logic                 res_status;
  logic [ROW_OUT_W-1:0] res_row;

  assign idx9     = {2'b00, cmd_idx};
  assign k1_wide  = {1'b0, k} + (CW + 1)'(1);
  assign k1       = k1_wide[CW-1:0];
  assign last_row = (r == RW'(CANVAS_H - 1));
  assign dy       = $signed(SQ_OP_W'(r)) - SQ_OP_W'(obj.pos_y);
  assign cand     = m | (COORD_W'(1) << bitn);
  assign cand_ok  = (cand <= obj.arg_a[COORD_W-1:0]) && (SQ_W'(prod) <= t);
  assign s_tready = (state == ST_IDLE);

  sdl_sq u_sq (
    .clk (clk),
    .op  (sq_op),
    .sq  (prod)
  );

  sdl_row #(.CANVAS_W(CANVAS_W)) u_row (
    .obj    (obj),
    .row    ($signed(SPAN_W'(r))),
    .half_w (m),
    .mask   (row_mask)
  );

  // next state and store controls
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = k[IW-1:0];
    mem_wdata  = cmd_obj;
    mem_raddr  = k[IW-1:0];
    fr_we      = 1'b0;
    fr_wdata   = acc | row_mask;
    sq_op      = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (cmd_r)
          CMD_ADD: begin
            if (total >= CW'(MAX_SHAPES)) begin
              state_next = ST_DONE;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = total[IW-1:0];
              state_next = ST_ROW_BEGIN;
            end
          end
          CMD_DEL: state_next = (idx9 >= 9'(total)) ? ST_DONE : ST_DEL_RD;
          CMD_MOD: state_next = (idx9 >= 9'(total)) ? ST_DONE : ST_MOD_RD;
          CMD_READ: state_next = ({1'b0, cmd_idx} >= 8'(CANVAS_H)) ? ST_DONE : ST_FR_RD;
          default: state_next = ST_DONE;
        endcase
      end
      ST_MOD_RD: begin
        mem_raddr  = idx9[IW-1:0];
        state_next = ST_MOD_WR;
      end
      ST_MOD_WR: begin
        // the stored shape type is kept
        mem_we          = 1'b1;
        mem_waddr       = idx9[IW-1:0];
        mem_wdata       = cmd_obj;
        mem_wdata.shape = rdata.shape;
        state_next      = ST_ROW_BEGIN;
      end
      ST_DEL_RD: begin
        if (k1 < total) begin
          mem_raddr  = k1[IW-1:0];
          state_next = ST_DEL_WR;
        end else begin
          state_next = ST_ROW_BEGIN;
        end
      end
      ST_DEL_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = rdata;
        state_next = ST_DEL_RD;
      end
      ST_ROW_BEGIN: begin
        if (total == '0) begin
          fr_we      = 1'b1;
          fr_wdata   = '0;
          state_next = last_row ? ST_DONE : ST_ROW_BEGIN;
        end else begin
          state_next = ST_OBJ_RD;
        end
      end
      ST_OBJ_RD: state_next = ST_OBJ_LD;
      ST_OBJ_LD: state_next = ST_SQ_A;
      ST_SQ_A: begin
        sq_op      = SQ_OP_W'(obj.arg_a);
        state_next = ST_SQ_DY;
      end
      ST_SQ_DY: begin
        sq_op      = dy;
        state_next = ST_SQ_T;
      end
      ST_SQ_T: begin
        if (obj.shape == SHP_CIRC && !obj.arg_a[COORD_W-1]) state_next = ST_SRCH;
        else state_next = ST_MASK;
      end
      ST_SRCH: begin
        sq_op      = $signed(SQ_OP_W'(cand));
        state_next = ST_CHK;
      end
      ST_CHK: begin
        state_next = (bitn == '0) ? ST_MASK : ST_SRCH;
      end
      ST_MASK: begin
        if (k1 == total) begin
          fr_we      = 1'b1;
          state_next = last_row ? ST_DONE : ST_ROW_BEGIN;
        end else begin
          state_next = ST_OBJ_RD;
        end
      end
      ST_FR_RD:  state_next = ST_FR_OUT;
      ST_FR_OUT: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // object store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) obj_mem[mem_waddr] <= mem_wdata;
    rdata <= obj_mem[mem_raddr];
  end

  // frame store
  always_ff @(posedge clk) begin
    if (fr_we) frame[r] <= fr_wdata;
    frame_q <= frame[cmd_idx[RW-1:0]];
  end

  // control counters and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      k         <= '0;
      r         <= '0;
      row_valid <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (fr_we) row_valid[r] <= 1'b1;
      unique case (state)
        ST_DECODE: begin
          r <= '0;
          k <= idx9[CW-1:0];
          if (cmd_r == CMD_ADD && total < CW'(MAX_SHAPES)) total <= total + CW'(1);
        end
        ST_DEL_RD: begin
          if (!(k1 < total)) total <= total - CW'(1);
        end
        ST_DEL_WR: k <= k1;
        ST_ROW_BEGIN: begin
          k <= '0;
          if (total == '0) r <= r + RW'(1);
        end
        ST_MASK: begin
          k <= k1;
          if (k1 == total) r <= r + RW'(1);
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) m_tvalid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd_r         <= cmd_t'(s_tdata[1:0]);
          cmd_idx       <= s_tdata[8:2];
          cmd_obj.shape <= shape_t'(s_tdata[10:9]);
          cmd_obj.pos_x <= s_tdata[20:11];
          cmd_obj.pos_y <= s_tdata[30:21];
          cmd_obj.arg_a <= s_tdata[40:31];
          cmd_obj.arg_b <= s_tdata[50:41];
          res_status    <= 1'b0;
          res_row       <= '0;
        end
      end
      ST_DECODE: begin
        unique case (cmd_r)
          CMD_ADD:  res_status <= (total >= CW'(MAX_SHAPES));
          CMD_DEL:  res_status <= (idx9 >= 9'(total));
          CMD_MOD:  res_status <= (idx9 >= 9'(total));
          CMD_READ: res_status <= ({1'b0, cmd_idx} >= 8'(CANVAS_H));
          default:  res_status <= 1'b1;
        endcase
      end
      ST_ROW_BEGIN: acc <= '0;
      ST_OBJ_LD:    obj <= rdata;
      ST_SQ_DY:     asq <= (SQ_W + 1)'(prod) + (SQ_W + 1)'(1);
      ST_SQ_T: begin
        t    <= asq - (SQ_W + 1)'(prod);
        m    <= '0;
        bitn <= BIT_W'(SRCH_STEPS - 1);
      end
      ST_CHK: begin
        if (cand_ok) m <= cand;
        bitn <= bitn - BIT_W'(1);
      end
      ST_MASK:   acc <= acc | row_mask;
      ST_FR_OUT: res_row <= row_valid[cmd_idx[RW-1:0]] ? ROW_OUT_W'(frame_q) : '0;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {(OUT_W - ROW_OUT_W - COUNT_W - 1)'(0), res_row,
                      COUNT_W'(total), res_status};
        end
      end
      default: ;
    endcase
  end

endmodule

[hdl/sdl_checker.sv]
// port-level checker for the display list rasterizer, bound to the top level
// depends on sdl_pkg and shape_display_list_rasterizer_defines.svh
`include "shape_display_list_rasterizer_defines.svh"

module sdl_checker import sdl_pkg::*; #(
  parameter int MAX_SHAPES = MAX_SHAPES_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // one item at a time: ready drops right after an accept
  `SDL_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready)
  // an ignored item never carries row pixels
  `SDL_ASSERT_ALWAYS(a_ignored_row_zero, (m_tvalid && m_tdata[0]) |-> (m_tdata[72:9] == '0))
  // the list never holds more than its capacity
  `SDL_ASSERT_ALWAYS(a_count_cap, m_tvalid |-> (m_tdata[8:1] <= MAX_SHAPES))
  // a stalled result stays offered
  `SDL_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> m_tvalid)

endmodule

bind shape_display_list_rasterizer sdl_checker #(.MAX_SHAPES(MAX_SHAPES)) u_sdl_checker (.*);
